// File: design/steq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steq_pkg
// shared result status codes, widths and rate reset value for the sorted timer event queue
// ----------------------------------------------------------------------------
package steq_pkg;

    typedef enum logic [1:0] {
        STATUS_ADDED   = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_EXPIRED = 2'd2
    } status_t;

    localparam int unsigned DELAY_BITS = 32;
    localparam int unsigned TIME_BITS  = 64;
    localparam int unsigned TPS_BITS   = 32;
    localparam logic [TPS_BITS-1:0] TPS_RESET = 32'd19200000;

endpackage

// File: design/steq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steq_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module steq_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/sorted_timer_event_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_event_queue
// tick counter with a deadline-ordered table of pending timer events
// ----------------------------------------------------------------------------
// An add beat (mode 0) computes deadline = now + delay, with delay scaled by
// ticks_per_second when given in seconds, and inserts the event behind every
// entry with an equal or earlier deadline; it always returns one result beat.
// A tick beat (mode 1) advances the count by one and returns one beat per
// expired head entry, the final one flagged by last, or none at all.
// The table lives in a ring held in one ram with a registered read. An add
// passes through the multiply and sum states; when the table is full it goes
// straight to a full result, else insertion walks back from the tail, moving
// each later deadline up one slot through a read state and a compare state,
// and puts the event at the head when every entry was later; the result beat
// follows. A tick checks the head and, when it is due and the output
// register is free, sends it out and reads the next head; each further
// expired event waits until the previous beat has left, so any wait on
// m_ready holds it. A tick with nothing due returns to idle with no beat.
// Inputs are taken one at a time, only while the block is idle.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue
    import steq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [TPS_BITS-1:0]              cfg_data,
    // input items
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_mode,
    input  logic [DELAY_BITS-1:0]            s_delay,
    input  logic                             s_delay_in_ticks,
    input  logic [TAG_BITS-1:0]              s_event_tag,
    // results
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_status,
    output logic [TAG_BITS-1:0]              m_tag_out,
    output logic [TIME_BITS-1:0]             m_deadline,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] m_pending_count,
    output logic [TIME_BITS-1:0]             m_next_deadline,
    output logic                             m_queue_empty,
    output logic                             m_last
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = TIME_BITS + TAG_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [CW:0]   DEPTH_W = (CW+1)'(QUEUE_DEPTH);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_MUL      = 9'b000000010,
        S_SUM      = 9'b000000100,
        S_INS_RD   = 9'b000001000,
        S_INS_CMP  = 9'b000010000,
        S_INS_PUT  = 9'b000100000,
        S_EMIT     = 9'b001000000,
        S_POP_CHK  = 9'b010000000,
        S_POP_WAIT = 9'b100000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [TPS_BITS-1:0]     tps_reg, tps_next;
    logic [TIME_BITS-1:0]    now_reg, now_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [TIME_BITS-1:0]    head_dl_reg, head_dl_next;
    logic [TAG_BITS-1:0]     head_tag_reg, head_tag_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [TIME_BITS-1:0]    dl_reg, dl_next;
    logic [TAG_BITS-1:0]     tag_reg, tag_next;
    logic [DELAY_BITS-1:0]   delay_reg, delay_next;
    logic                    by_tick_reg, by_tick_next;
    logic [TIME_BITS-1:0]    prod_reg, prod_next;
    status_t                 stat_reg, stat_next;

    logic                    m_valid_reg, m_valid_next;
    logic [1:0]              m_status_reg, m_status_next;
    logic [TAG_BITS-1:0]     m_tag_reg, m_tag_next;
    logic [TIME_BITS-1:0]    m_dl_reg, m_dl_next;
    logic [CW-1:0]           m_cnt_reg, m_cnt_next;
    logic [TIME_BITS-1:0]    m_ndl_reg, m_ndl_next;
    logic                    m_empty_reg, m_empty_next;
    logic                    m_last_reg, m_last_next;

    // ram ports
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [EW-1:0]           ram_wdata, ram_rdata;
    logic [TIME_BITS-1:0]    rd_dl;
    logic [TAG_BITS-1:0]     rd_tag;
    logic                    out_free;

    assign rd_dl  = ram_rdata[EW-1:TAG_BITS];
    assign rd_tag = ram_rdata[TAG_BITS-1:0];

    // logical slot to ram address around the ring head
    function automatic logic [AW-1:0] slot_addr(input logic [AW-1:0] head,
                                                input logic [CW-1:0] slot);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(slot);
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    steq_ram #(
        .WIDTH(EW),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        tps_next      = tps_reg;
        now_next      = now_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        head_dl_next  = head_dl_reg;
        head_tag_next = head_tag_reg;
        idx_next      = idx_reg;
        dl_next       = dl_reg;
        tag_next      = tag_reg;
        delay_next    = delay_reg;
        by_tick_next  = by_tick_reg;
        prod_next     = prod_reg;
        stat_next     = stat_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_tag_next    = m_tag_reg;
        m_dl_next     = m_dl_reg;
        m_cnt_next    = m_cnt_reg;
        m_ndl_next    = m_ndl_reg;
        m_empty_next  = m_empty_reg;
        m_last_next   = m_last_reg;

        ram_we    = 1'b0;
        ram_waddr = slot_addr(head_reg, idx_reg);
        ram_wdata = {dl_reg, tag_reg};
        ram_raddr = slot_addr(head_reg, idx_reg - CW'(1));

        if (cfg_valid) begin
            tps_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    delay_next   = s_delay;
                    by_tick_next = s_delay_in_ticks;
                    tag_next     = s_event_tag;
                    if (s_mode) begin
                        now_next   = now_reg + TIME_BITS'(1);
                        state_next = S_POP_CHK;
                    end else begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: begin
                // seconds scaled by the tick rate (ticks pass through), registered before the sum
                prod_next  = by_tick_reg ? TIME_BITS'(delay_reg)
                                         : TIME_BITS'(tps_reg) * TIME_BITS'(delay_reg);
                state_next = S_SUM;
            end
            S_SUM: begin
                dl_next = now_reg + prod_reg;
                idx_next = count_reg;
                if (count_reg == DEPTH_C) begin
                    stat_next  = STATUS_FULL;
                    state_next = S_EMIT;
                end else if (count_reg == '0) begin
                    state_next = S_INS_PUT;
                end else begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD: begin
                // read slot idx-1 (default read address)
                state_next = S_INS_CMP;
            end
            S_INS_CMP: begin
                ram_we = 1'b1;
                if (rd_dl > dl_reg) begin
                    // later deadline moves up one slot
                    ram_wdata = ram_rdata;
                    idx_next  = idx_reg - CW'(1);
                    state_next = (idx_reg == CW'(1)) ? S_INS_PUT : S_INS_RD;
                end else begin
                    stat_next  = STATUS_ADDED;
                    count_next = count_reg + CW'(1);
                    state_next = S_EMIT;
                end
            end
            S_INS_PUT: begin
                // new event becomes the head
                ram_we        = 1'b1;
                ram_waddr     = head_reg;
                head_dl_next  = dl_reg;
                head_tag_next = tag_reg;
                stat_next     = STATUS_ADDED;
                count_next    = count_reg + CW'(1);
                state_next    = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = stat_reg;
                    m_tag_next    = tag_reg;
                    m_dl_next     = dl_reg;
                    m_cnt_next    = count_reg;
                    m_ndl_next    = head_dl_reg;
                    m_empty_next  = 1'b0;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_POP_CHK: begin
                ram_raddr = slot_addr(head_reg, CW'(1));
                if (count_reg != '0 && head_dl_reg <= now_reg) begin
                    if (!m_valid_reg) begin
                        state_next = S_POP_WAIT;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_POP_WAIT: begin
                // output stage was empty when the read went out
                m_valid_next  = 1'b1;
                m_status_next = STATUS_EXPIRED;
                m_tag_next    = head_tag_reg;
                m_dl_next     = head_dl_reg;
                m_cnt_next    = count_reg - CW'(1);
                m_ndl_next    = (count_reg > CW'(1)) ? rd_dl : '0;
                m_empty_next  = (count_reg == CW'(1));
                m_last_next   = !(count_reg > CW'(1) && rd_dl <= now_reg);
                head_next     = slot_addr(head_reg, CW'(1));
                head_dl_next  = rd_dl;
                head_tag_next = rd_tag;
                count_next    = count_reg - CW'(1);
                state_next    = S_POP_CHK;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            tps_reg     <= TPS_RESET;
            now_reg     <= '0;
            count_reg   <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tps_reg     <= tps_next;
            now_reg     <= now_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        head_dl_reg  <= head_dl_next;
        head_tag_reg <= head_tag_next;
        idx_reg      <= idx_next;
        dl_reg       <= dl_next;
        tag_reg      <= tag_next;
        delay_reg    <= delay_next;
        by_tick_reg  <= by_tick_next;
        prod_reg     <= prod_next;
        stat_reg     <= stat_next;
        m_status_reg <= m_status_next;
        m_tag_reg    <= m_tag_next;
        m_dl_reg     <= m_dl_next;
        m_cnt_reg    <= m_cnt_next;
        m_ndl_reg    <= m_ndl_next;
        m_empty_reg  <= m_empty_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_tag_out       = m_tag_reg;
    assign m_deadline      = m_dl_reg;
    assign m_pending_count = m_cnt_reg;
    assign m_next_deadline = m_ndl_reg;
    assign m_queue_empty   = m_empty_reg;
    assign m_last          = m_last_reg;

`ifndef SYNTH
    // table never holds more than its depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count beyond depth");

    // an add result is always flagged last, since an add answers with exactly one beat
    a_add_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_EXPIRED |-> m_last)
        else $error("add result without last");

    // empty flag agrees with the reported count
    a_empty_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_queue_empty == (m_pending_count == '0)))
        else $error("empty flag mismatch");

    // an expiry never reports a deadline after the current count
    a_expired_due: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_EXPIRED |-> m_deadline <= now_reg)
        else $error("expired event not due");
`endif

endmodule

// File: test/sorted_timer_event_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_event_queue_tb
// self-checking bench for the sorted timer event queue
// ----------------------------------------------------------------------------
// A local model keeps its own tick count, deadline table and rate register.
// Every accepted input beat is run through it, and the result beats it gives
// are queued. A monitor compares each result beat with the oldest queued one.
// Named tests cover ordering, a full table, the rate register and back
// pressure. Random traffic then runs with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue_tb;
    import steq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;
    // an add may walk the whole table, so allow that much quiet time
    localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 12;

    typedef struct {
        status_t                status;
        logic [TAG_BITS-1:0]    tag;
        logic [TIME_BITS-1:0]   deadline;
        logic [CNT_BITS-1:0]    pending;
        logic [TIME_BITS-1:0]   next_deadline;
        logic                   empty;
        logic                   last;
    } timer_result_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [TPS_BITS-1:0]        cfg_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_mode = 1'b0;
    logic [DELAY_BITS-1:0]      s_delay = '0;
    logic                       s_delay_in_ticks = 1'b0;
    logic [TAG_BITS-1:0]        s_event_tag = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [1:0]                 m_status;
    logic [TAG_BITS-1:0]        m_tag_out;
    logic [TIME_BITS-1:0]       m_deadline;
    logic [CNT_BITS-1:0]        m_pending_count;
    logic [TIME_BITS-1:0]       m_next_deadline;
    logic                       m_queue_empty;
    logic                       m_last;

    sorted_timer_event_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TAG_BITS   (TAG_BITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_delay         (s_delay),
        .s_delay_in_ticks(s_delay_in_ticks),
        .s_event_tag     (s_event_tag),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_tag_out       (m_tag_out),
        .m_deadline      (m_deadline),
        .m_pending_count (m_pending_count),
        .m_next_deadline (m_next_deadline),
        .m_queue_empty   (m_queue_empty),
        .m_last          (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // local copy of the block state
    logic [TPS_BITS-1:0]  model_tps;
    logic [TIME_BITS-1:0] model_now;
    logic [TIME_BITS-1:0] model_deadlines [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]  model_tags [QUEUE_DEPTH];
    int                   model_count;

    timer_result_t pending_results [$];

    int mismatches = 0;
    int n_adds = 0, n_ticks = 0, n_expired = 0, n_full = 0, n_cfg = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int stall_style = 0;

    // runs one accepted beat through the local model, queueing its results
    task automatic apply_item(input logic mode, input logic [DELAY_BITS-1:0] delay,
                              input logic in_ticks, input logic [TAG_BITS-1:0] tag);
        timer_result_t        r;
        logic [TIME_BITS-1:0] dl;
        int                   pos;
        int                   n;
        if (mode == MODE_ADD) begin
            n_adds++;
            dl = model_now + (in_ticks ? TIME_BITS'(delay)
                                       : TIME_BITS'(model_tps) * TIME_BITS'(delay));
            r.tag = tag;
            r.deadline = dl;
            r.last = 1'b1;
            if (model_count >= QUEUE_DEPTH) begin
                r.status = STATUS_FULL;
                n_full++;
            end else begin
                // equal deadlines queue behind the older entries
                pos = 0;
                while (pos < model_count && model_deadlines[pos] <= dl) pos++;
                for (int i = model_count; i > pos; i--) begin
                    model_deadlines[i] = model_deadlines[i-1];
                    model_tags[i] = model_tags[i-1];
                end
                model_deadlines[pos] = dl;
                model_tags[pos] = tag;
                model_count++;
                r.status = STATUS_ADDED;
            end
            r.pending = CNT_BITS'(model_count);
            r.next_deadline = model_count ? model_deadlines[0] : '0;
            r.empty = (model_count == 0);
            pending_results.push_back(r);
        end else begin
            n_ticks++;
            n = 0;
            model_now = model_now + 1;
            while (model_count > 0 && model_deadlines[0] <= model_now) begin
                r.status = STATUS_EXPIRED;
                r.tag = model_tags[0];
                r.deadline = model_deadlines[0];
                for (int i = 1; i < model_count; i++) begin
                    model_deadlines[i-1] = model_deadlines[i];
                    model_tags[i-1] = model_tags[i];
                end
                model_count--;
                r.pending = CNT_BITS'(model_count);
                r.next_deadline = model_count ? model_deadlines[0] : '0;
                r.empty = (model_count == 0);
                r.last = 1'b0;
                pending_results.push_back(r);
                n++;
                n_expired++;
            end
            if (n > 0) pending_results[pending_results.size()-1].last = 1'b1;
        end
    endtask

    // offers one beat and holds it until taken; valid stays up for a following beat unless a burst gap closes it
    task automatic send_item(input logic mode, input logic [DELAY_BITS-1:0] delay,
                             input logic in_ticks, input logic [TAG_BITS-1:0] tag);
        s_valid <= 1'b1;
        s_mode <= mode;
        s_delay <= delay;
        s_delay_in_ticks <= in_ticks;
        s_event_tag <= tag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_item(mode, delay, in_ticks, tag);
        // burst bookkeeping: close the burst with a random gap
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                        : $urandom_range(1, 8);
            end
        end
    endtask

    task automatic add_ticks(input logic [DELAY_BITS-1:0] d, input logic [TAG_BITS-1:0] t);
        send_item(MODE_ADD, d, 1'b1, t);
    endtask

    task automatic tick();
        send_item(MODE_TICK, $urandom, 1'($urandom_range(0, 1)), TAG_BITS'($urandom));
    endtask

    // wait for every expected beat, then for any tick still being worked on
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_rate(input logic [TPS_BITS-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        model_tps = v;
        n_cfg++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // result monitor and output stall pattern
    always @(posedge aclk) begin
        timer_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status %0d tag %h deadline %h",
                             m_status, m_tag_out, m_deadline);
            end else begin
                e = pending_results.pop_front();
                if (m_status !== e.status || m_tag_out !== e.tag ||
                    m_deadline !== e.deadline || m_pending_count !== e.pending ||
                    m_next_deadline !== e.next_deadline ||
                    m_queue_empty !== e.empty || m_last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp: st %0d tag %h dl %h cnt %0d nxt %h emp %b last %b",
                                 e.status, e.tag, e.deadline, e.pending,
                                 e.next_deadline, e.empty, e.last);
                        $display("         got: st %0d tag %h dl %h cnt %0d nxt %h emp %b last %b",
                                 m_status, m_tag_out, m_deadline, m_pending_count,
                                 m_next_deadline, m_queue_empty, m_last);
                    end
                end
            end
        end
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 63) == 0) stall_style = $urandom_range(0, 2);
            case (stall_style)
                0: m_ready <= 1'b1;                          // no stalls
                1: m_ready <= ($urandom_range(0, 3) != 0);   // light stalls
                default: m_ready <= ($urandom_range(0, 2) == 0); // heavy stalls
            endcase
        end
    end

    // basic adds and ticks, zero delay, tag extremes, seconds at reset rate
    task automatic test_basic();
        add_ticks(0, 16'h0000);
        add_ticks(2, 16'hffff);
        send_item(MODE_ADD, 1, 1'b0, 16'h1234);   // one second at reset rate
        tick();                                   // zero delay entry falls due
        tick();
        tick();                                   // nothing due
    endtask

    // equal deadlines leave in arrival order, all in one tick
    task automatic test_equal_deadlines();
        for (int i = 0; i < 4; i++) add_ticks(3, TAG_BITS'(16'ha000 + i));
        add_ticks(1, 16'h5555);
        repeat (3) tick();
    endtask

    // fill the table, hit full, then tick until the entries just added have expired
    task automatic test_full_table();
        for (int i = 0; i < QUEUE_DEPTH; i++)
            add_ticks($urandom_range(2, 4), TAG_BITS'($urandom));
        add_ticks(1, 16'hdead);
        send_item(MODE_ADD, 32'hffff_ffff, 1'b0, 16'hbeef);
        drain();
        hold_req = 1'b1;                          // long output hold while input waits
        repeat (5) tick();
    endtask

    // rate register extremes, including zero
    task automatic test_rate_register();
        write_rate(0);
        send_item(MODE_ADD, 32'hffff_ffff, 1'b0, 16'h0f0f);   // lands on now
        tick();
        write_rate(1);
        send_item(MODE_ADD, 2, 1'b0, 16'hf0f0);
        repeat (2) tick();
        write_rate(32'hffff_ffff);
    endtask

    // mixed random traffic, mostly near deadlines so entries keep expiring
    task automatic test_random(input int count);
        logic [DELAY_BITS-1:0] d;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 48) begin
                tick();
            end else if ($urandom_range(0, 3) == 0) begin
                d = $urandom_range(0, 4);
                send_item(MODE_ADD, d, 1'b0, TAG_BITS'($urandom));
            end else begin
                d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
                add_ticks(d, TAG_BITS'($urandom));
            end
        end
    endtask

    // far deadlines exercise every delay bit; they never expire, so run last
    task automatic test_far_deadlines();
        write_rate(32'hffff_ffff);
        send_item(MODE_ADD, 32'hffff_ffff, 1'b0, 16'h0001);
        add_ticks(32'hffff_ffff, 16'h0002);
        add_ticks(32'h5555_5555, 16'h0003);
        add_ticks(32'haaaa_aaaa, 16'h0004);
        for (int i = 0; i < 14; i++) add_ticks($urandom, TAG_BITS'($urandom));
        tick();
    endtask

    initial begin
        model_tps = TPS_RESET;
        model_now = '0;
        model_count = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic();
        test_equal_deadlines();
        test_full_table();
        test_rate_register();
        write_rate(3);
        test_random(120);
        write_rate(1);
        gaps_on = 1'b0;                           // back-to-back stretch
        test_random(60);
        gaps_on = 1'b1;
        write_rate(2);
        test_random(120);
        write_rate(TPS_RESET);
        test_random(10);
        test_far_deadlines();

        drain();
        $display("covered %0d adds, %0d ticks, %0d expiries, %0d full rejects, %0d rate writes",
                 n_adds, n_ticks, n_expired, n_full, n_cfg);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("sorted_timer_event_queue test passed");
        end else begin
            $display("%0d mismatches, %0d beats outstanding", mismatches,
                     pending_results.size());
            $display("sorted_timer_event_queue test failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout with %0d beats outstanding", pending_results.size());
        $display("sorted_timer_event_queue test failed");
        $finish;
    end

endmodule

// File: sim.f
design/steq_pkg.sv
design/steq_ram.sv
design/sorted_timer_event_queue.sv
test/sorted_timer_event_queue_tb.sv
